[design/emg_window_feature_extractor_macros.svh]
// Assertion macros used by the checker file of the EMG feature extractor.
`ifndef EMG_WINDOW_FEATURE_EXTRACTOR_MACROS_SVH
`define EMG_WINDOW_FEATURE_EXTRACTOR_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define EFX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("EMG feature extractor: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define EFX_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("EMG feature extractor: same-cycle check failed");

`endif

[design/efx_pkg.sv]
// Types and constants shared by the EMG window feature extractor files.
package efx_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned MAV_W    = 16;
  localparam int unsigned WL_W     = 24;
  localparam int unsigned ZC_W     = 12;
  localparam int unsigned SSC_W    = 12;
  localparam int unsigned RMS_W    = 16;
  localparam int unsigned SQR_W    = 23;
  localparam int unsigned RAD_W    = 32;
  localparam int unsigned ROOT_W   = 16;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 13'd1000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
  } efx_in_t;

  typedef struct packed {
    logic [MAV_W-1:0] mean_abs;
    logic [WL_W-1:0]  wave_length;
    logic [ZC_W-1:0]  zero_crossings;
    logic [SSC_W-1:0] slope_changes;
    logic [RMS_W-1:0] rms_value;
  } efx_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] window_length;
  } efx_cfg_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } efx_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } efx_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV_START,
    ST_DIV_MAV,
    ST_DIV_MS,
    ST_ROOT,
    ST_OUT
  } efx_state_e;

endpackage

[design/efx_chan_if.sv]
// Valid/ready channel that carries one word of a given payload type.
interface efx_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/efx_divsqrt.sv]
// Shared compare-subtract unit that runs restoring division or integer square root.
module efx_divsqrt #(
  parameter int unsigned CNT_W = 13,
  parameter int unsigned DVD_W = 43
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  efx_pkg::efx_cmd_t        cmd_i,
  input  logic [DVD_W-1:0]         opnd_i,
  input  logic [CNT_W-1:0]         divisor_i,
  output efx_pkg::efx_sts_t        sts_o,
  output logic [efx_pkg::RAD_W-1:0] result_o
);
  import efx_pkg::*;

  localparam int unsigned REM_W  = CNT_W + 1;
  localparam int unsigned SUB_W  = (REM_W > ROOT_W + 3) ? REM_W : ROOT_W + 3;
  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  opnd_q, opnd_d;
  logic [SUB_W-1:0]  rem_q, rem_d;
  logic [RAD_W-1:0]  res_q, res_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic              sqrt_q, sqrt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [SUB_W-1:0] sub_a;
  logic [SUB_W-1:0] sub_b;
  logic [SUB_W:0]   diff;
  logic             fits;

  always_comb begin
    if (sqrt_q) begin
      sub_a = {rem_q[SUB_W-3:0], opnd_q[DVD_W-1 -: 2]};
      sub_b = SUB_W'({res_q[ROOT_W-1:0], 2'b01});
    end else begin
      sub_a = {rem_q[SUB_W-2:0], opnd_q[DVD_W-1]};
      sub_b = SUB_W'(div_q);
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    fits = !diff[SUB_W];
  end

  always_comb begin
    opnd_d = opnd_q;
    rem_d  = rem_q;
    res_d  = res_q;
    div_d  = div_q;
    sqrt_d = sqrt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (cmd_i.start) begin
      opnd_d = opnd_i;
      rem_d  = '0;
      res_d  = '0;
      div_d  = divisor_i;
      sqrt_d = cmd_i.is_sqrt;
      busy_d = 1'b1;
      step_d = cmd_i.is_sqrt ? STEP_W'(ROOT_W) : STEP_W'(DVD_W);
    end else if (busy_q) begin
      opnd_d = sqrt_q ? (opnd_q << 2) : (opnd_q << 1);
      rem_d  = fits ? diff[SUB_W-1:0] : sub_a;
      res_d  = {res_q[RAD_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    div_q  <= div_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign result_o   = res_q;

endmodule

[design/emg_window_feature_extractor.sv]
// Top level of the EMG window feature extractor: per-sample accumulation and window close.
// Each accepted word holds one signed, zero-centered sample; samples are gathered into
// non-overlapping windows of window_length samples (zero reads as one, values above
// MAX_WINDOW saturate), and when a window closes one word carries its mean absolute value,
// waveform length, zero crossings, slope sign changes and RMS. An ordinary sample passes
// through the accept state and one accumulate state with the 12 by 12 bit square. The
// closing sample also runs the shared compare-subtract unit three times, two divisions of
// D = clog2(MAX_WINDOW + 1) + 30 steps each and a 16-step square root, each followed by a
// done strobe, and then waits until the previous word has left the output register. A
// finished word waits in an output register while the next window is being filled.
module emg_window_feature_extractor #(
  parameter int unsigned MAX_WINDOW = 4096
) (
  input logic        clk_i,
  input logic        rst_ni,
  efx_chan_if.sink   in_ch,
  efx_chan_if.source out_ch,
  efx_chan_if.sink   cfg_ch
);
  import efx_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned ABS_W = CNT_W + SAMPLE_W - 1;
  localparam int unsigned SQS_W = CNT_W + 2 * (SAMPLE_W - 1);
  localparam int unsigned DVD_W = SQS_W + 8;

  efx_state_e state_q, state_d;

  logic [CFG_W-1:0]           wlen_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] prev_q, prev_d;
  logic signed [SAMPLE_W:0]   pdiff_q, pdiff_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [ABS_W-1:0]           abs_q, abs_d;
  logic [WL_W-1:0]            wl_q, wl_d;
  logic [ZC_W-1:0]            zc_q, zc_d;
  logic [SSC_W-1:0]           ssc_q, ssc_d;
  logic [SQS_W-1:0]           sq_q, sq_d;
  logic [MAV_W-1:0]           mav_q;
  logic [RMS_W-1:0]           rms_q;
  logic                       outv_q, outv_d;
  efx_out_t                   out_q;

  logic [CMP_W-1:0]           len_ext;
  logic [CMP_W-1:0]           len_eff;
  logic [CNT_W-1:0]           cnt_inc;
  logic                       close;
  logic [SAMPLE_W-1:0]        abs_s;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic signed [SAMPLE_W:0]   d1;
  logic signed [SAMPLE_W:0]   d1_neg;
  logic [SAMPLE_W-1:0]        abs_d1;
  logic                       s_pos, s_neg, p_pos, p_neg;
  logic                       d1_pos, d1_neg_s, d0_pos, d0_neg;
  logic                       load;

  efx_cmd_t                   cmd;
  efx_sts_t                   sts;
  logic [DVD_W-1:0]           opnd;
  logic [RAD_W-1:0]           result;

  efx_divsqrt #(
    .CNT_W(CNT_W),
    .DVD_W(DVD_W)
  ) u_divsqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .opnd_i    (opnd),
    .divisor_i (cnt_q),
    .sts_o     (sts),
    .result_o  (result)
  );

  always_comb begin
    len_ext = CMP_W'(wlen_q);
    if (wlen_q == '0) begin
      len_eff = CMP_W'(1);
    end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
      len_eff = CMP_W'(MAX_WINDOW);
    end else begin
      len_eff = len_ext;
    end
    cnt_inc = cnt_q + CNT_W'(1);
    close   = CMP_W'(cnt_inc) >= len_eff;
  end

  always_comb begin
    abs_s    = sample_q[SAMPLE_W-1] ? (~sample_q + SAMPLE_W'(1)) : sample_q;
    sq_full  = sample_q * sample_q;
    d1       = $signed({sample_q[SAMPLE_W-1], sample_q}) - $signed({prev_q[SAMPLE_W-1], prev_q});
    d1_neg   = -d1;
    abs_d1   = d1[SAMPLE_W] ? d1_neg[SAMPLE_W-1:0] : d1[SAMPLE_W-1:0];
    s_neg    = sample_q[SAMPLE_W-1];
    s_pos    = !sample_q[SAMPLE_W-1] && (|sample_q);
    p_neg    = prev_q[SAMPLE_W-1];
    p_pos    = !prev_q[SAMPLE_W-1] && (|prev_q);
    d1_neg_s = d1[SAMPLE_W];
    d1_pos   = !d1[SAMPLE_W] && (|d1);
    d0_neg   = pdiff_q[SAMPLE_W];
    d0_pos   = !pdiff_q[SAMPLE_W] && (|pdiff_q);
  end

  always_comb begin
    state_d      = state_q;
    cmd          = '0;
    opnd         = DVD_W'({abs_q, 4'b0000});
    load         = 1'b0;
    in_ch.ready  = (state_q == ST_IDLE);
    cfg_ch.ready = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = close ? ST_DIV_START : ST_IDLE;
      end
      ST_DIV_START: begin
        if (!sts.busy) begin
          cmd.start = 1'b1;
          state_d   = ST_DIV_MAV;
        end
      end
      ST_DIV_MAV: begin
        if (sts.done) begin
          cmd.start = 1'b1;
          opnd      = DVD_W'({sq_q, 8'h00});
          state_d   = ST_DIV_MS;
        end
      end
      ST_DIV_MS: begin
        if (sts.done) begin
          cmd.start   = 1'b1;
          cmd.is_sqrt = 1'b1;
          opnd        = DVD_W'(result) << (DVD_W - RAD_W);
          state_d     = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sts.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!outv_q || out_ch.ready) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    prev_d  = prev_q;
    pdiff_d = pdiff_q;
    cnt_d   = cnt_q;
    abs_d   = abs_q;
    wl_d    = wl_q;
    zc_d    = zc_q;
    ssc_d   = ssc_q;
    sq_d    = sq_q;
    if (state_q == ST_ACC) begin
      prev_d  = sample_q;
      pdiff_d = d1;
      cnt_d   = cnt_inc;
      abs_d   = abs_q + ABS_W'(abs_s);
      sq_d    = sq_q + SQS_W'(sq_full[SQR_W-1:0]);
      if (cnt_q != '0) begin
        wl_d = wl_q + WL_W'(abs_d1);
        if ((s_pos && p_neg) || (s_neg && p_pos)) begin
          zc_d = zc_q + ZC_W'(1);
        end
        if ((cnt_q >= CNT_W'(2)) && ((d1_pos && d0_neg) || (d1_neg_s && d0_pos))) begin
          ssc_d = ssc_q + SSC_W'(1);
        end
      end
    end else if (load) begin
      prev_d  = '0;
      pdiff_d = '0;
      cnt_d   = '0;
      abs_d   = '0;
      wl_d    = '0;
      zc_d    = '0;
      ssc_d   = '0;
      sq_d    = '0;
    end
  end

  always_comb begin
    outv_d = outv_q;
    if (out_ch.ready) begin
      outv_d = 1'b0;
    end
    if (load) begin
      outv_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wlen_q  <= WINDOW_RESET;
      prev_q  <= '0;
      pdiff_q <= '0;
      cnt_q   <= '0;
      abs_q   <= '0;
      wl_q    <= '0;
      zc_q    <= '0;
      ssc_q   <= '0;
      sq_q    <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_ch.valid) begin
        wlen_q <= cfg_ch.data.window_length;
      end
      prev_q  <= prev_d;
      pdiff_q <= pdiff_d;
      cnt_q   <= cnt_d;
      abs_q   <= abs_d;
      wl_q    <= wl_d;
      zc_q    <= zc_d;
      ssc_q   <= ssc_d;
      sq_q    <= sq_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_q <= in_ch.data.sample;
    end
    if ((state_q == ST_DIV_MAV) && sts.done) begin
      mav_q <= result[MAV_W-1:0];
    end
    if ((state_q == ST_ROOT) && sts.done) begin
      rms_q <= result[RMS_W-1:0];
    end
    if (load) begin
      out_q.mean_abs       <= mav_q;
      out_q.wave_length    <= wl_q;
      out_q.zero_crossings <= zc_q;
      out_q.slope_changes  <= ssc_q;
      out_q.rms_value      <= rms_q;
    end
  end

  assign out_ch.valid = outv_q;
  assign out_ch.data  = out_q;

endmodule

[design/efx_checker.sv]
// Port-level assertion checker for the EMG window feature extractor and its bind.
`include "emg_window_feature_extractor_macros.svh"

module efx_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // After a sample word is taken, the block is busy accumulating it.
  `EFX_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // A result word that is not taken stays offered.
  `EFX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A new result word only appears when the sample input was not ready just before it.
  `EFX_ASSERT_SAME(a_out_after_busy, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i))

endmodule

bind emg_window_feature_extractor efx_checker u_efx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready)
);

[test/tb_top.sv]
// Self-checking testbench for the EMG window feature extractor with a windowed feature scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import efx_pkg::*;

  localparam int WINDOW_CAP    = 4096;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 160;
  localparam int RANDOM_ITEMS  = 520;
  localparam int EXTREME_ITEMS = 48;
  localparam int SAMPLE_MAX    = 2047;
  localparam int SAMPLE_MIN    = -2048;

  typedef enum int {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  class feature_scoreboard;
    logic [CFG_W-1:0] window_len;
    int               taken;
    int               prev_smp;
    int               prev2_smp;
    longint unsigned  abs_acc;
    longint unsigned  diff_acc;
    longint unsigned  sq_acc;
    int unsigned      zc_acc;
    int unsigned      ssc_acc;
    efx_out_t         expected_windows[$];
    int unsigned      fail_count;

    function new();
      window_len = WINDOW_RESET;
      fail_count = 0;
      clear_window();
    endfunction

    function void clear_window();
      taken     = 0;
      prev_smp  = 0;
      prev2_smp = 0;
      abs_acc   = 0;
      diff_acc  = 0;
      sq_acc    = 0;
      zc_acc    = 0;
      ssc_acc   = 0;
    endfunction

    function void set_window(logic [CFG_W-1:0] len);
      window_len = len;
    endfunction

    function int pending();
      return expected_windows.size();
    endfunction

    function longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 24; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= v) r = trial;
      end
      return r;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] smp);
      int              s;
      int              d1;
      int              d0;
      int              lim;
      longint unsigned n;
      efx_out_t        w;
      s = smp;
      if (window_len == 0) lim = 1;
      else if (int'(window_len) > WINDOW_CAP) lim = WINDOW_CAP;
      else lim = int'(window_len);
      abs_acc += 64'((s < 0) ? -s : s);
      sq_acc  += 64'(s * s);
      if (taken >= 1) begin
        d1 = s - prev_smp;
        diff_acc += 64'((d1 < 0) ? -d1 : d1);
        if ((s > 0 && prev_smp < 0) || (s < 0 && prev_smp > 0)) zc_acc++;
        if (taken >= 2) begin
          d0 = prev_smp - prev2_smp;
          if ((d1 > 0 && d0 < 0) || (d1 < 0 && d0 > 0)) ssc_acc++;
        end
      end
      prev2_smp = prev_smp;
      prev_smp  = s;
      taken++;
      if (taken >= lim) begin
        n = 64'(taken);
        w.mean_abs       = MAV_W'((abs_acc * 16) / n);
        w.wave_length    = WL_W'(diff_acc);
        w.zero_crossings = ZC_W'(zc_acc);
        w.slope_changes  = SSC_W'(ssc_acc);
        w.rms_value      = RMS_W'(floor_root((sq_acc * 256) / n));
        expected_windows.push_back(w);
        clear_window();
      end
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_word(efx_out_t got);
      efx_out_t want;
      if (expected_windows.size() == 0) begin
        $error("result word with no window pending: mean_abs %0d, wave_length %0d",
               got.mean_abs, got.wave_length);
        fail_count++;
        return;
      end
      want = expected_windows.pop_front();
      compare_field("mean_abs", want.mean_abs, got.mean_abs);
      compare_field("wave_length", want.wave_length, got.wave_length);
      compare_field("zero_crossings", want.zero_crossings, got.zero_crossings);
      compare_field("slope_changes", want.slope_changes, got.slope_changes);
      compare_field("rms_value", want.rms_value, got.rms_value);
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       hold_req;
  logic signed [SAMPLE_W-1:0] last_sample = '0;
  int unsigned                burst_left = 0;
  feature_scoreboard          feat_sb;

  efx_chan_if #(.T(efx_in_t))  in_if ();
  efx_chan_if #(.T(efx_out_t)) out_if ();
  efx_chan_if #(.T(efx_cfg_t)) cfg_if ();

  emg_window_feature_extractor #(
    .MAX_WINDOW(WINDOW_CAP)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    in_if.valid       <= 1'b1;
    in_if.data.sample <= smp;
    do @(posedge clk); while (!in_if.ready);
    feat_sb.note_sample(smp);
    last_sample = smp;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_window(input logic [CFG_W-1:0] len);
    cfg_if.valid              <= 1'b1;
    cfg_if.data.window_length <= len;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    feat_sb.set_window(len);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (feat_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r = SAMPLE_W'($urandom());
      4, 5:       r = SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
      6: begin
        case ($urandom_range(0, 2))
          0:       r = SAMPLE_W'(SAMPLE_MAX);
          1:       r = SAMPLE_W'(SAMPLE_MIN);
          default: r = '0;
        endcase
      end
      7:          r = last_sample;
      default:    r = SAMPLE_W'(int'(last_sample) + int'($urandom_range(0, 8)) - 4);
    endcase
    return r;
  endfunction

  // The receiver owns its own stall pattern; a hold request starts one long hold-off.
  initial begin
    int       hold_left;
    int       pat_left;
    rx_mode_e pat_mode;
    hold_left = 0;
    pat_left  = 0;
    pat_mode  = RX_OPEN;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_left = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_mode = rx_mode_e'($urandom_range(0, 3));
          pat_left = $urandom_range(16, 96);
        end else begin
          pat_left--;
        end
        case (pat_mode)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_if.ready <= pat_left[2];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) feat_sb.check_word(out_if.data);
  end

  initial begin
    int sent;
    int chunk;
    int len;
    feat_sb = new();
    rst_n        <= 1'b0;
    hold_req     <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A partial window under the reset length is closed early by a shorter length.
    push_sample('0);
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample(SAMPLE_W'(SAMPLE_MIN));
    drain_results();
    write_window(13'd2);
    push_sample(-12'sd1);

    drain_results();
    write_window('0);
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample(SAMPLE_W'(SAMPLE_MIN));
    push_sample('0);

    drain_results();
    write_window(13'd3);
    push_sample(12'sd5);
    push_sample(-12'sd5);
    push_sample(12'sd5);
    push_sample('0);
    push_sample('0);
    push_sample('0);
    push_sample(12'sd3);
    push_sample('0);
    push_sample(-12'sd3);
    push_sample(12'sd1);
    push_sample(12'sd1);
    push_sample(12'sd2);

    drain_results();
    write_window(13'h1FFF);
    push_sample(12'sd7);
    push_sample(-12'sd7);
    drain_results();
    write_window(13'd1);
    push_sample(12'sd9);

    drain_results();
    write_window(13'd1);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (40) push_sample(rand_sample());

    drain_results();
    write_window(CFG_W'(EXTREME_ITEMS));
    for (int i = 0; i < EXTREME_ITEMS; i++) begin
      push_sample((i % 2 != 0) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(SAMPLE_MIN));
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      case ($urandom_range(0, 15))
        0:       len = 0;
        1:       len = $urandom_range(WINDOW_CAP + 1, 8191);
        2:       len = $urandom_range(25, 120);
        default: len = $urandom_range(1, 24);
      endcase
      write_window(CFG_W'(len));
      chunk = $urandom_range(1, 60);
      repeat (chunk) push_sample(rand_sample());
      sent += chunk;
    end

    drain_results();
    if (feat_sb.fail_count == 0 && feat_sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
